[hdl/msks_pkg.sv]
// Package for the modular sum key sorter: state encoding, command codes and
// the serial reduction constants. No dependencies.
package msks_pkg;

  localparam int unsigned KeyW    = 31;
  localparam int unsigned SumW    = 32;
  localparam int unsigned StepW   = 5;
  localparam int unsigned IndexW  = 6;

  localparam logic [1:0] CmdAdd      = 2'd0;
  localparam logic [1:0] CmdCloseLst = 2'd1;
  localparam logic [1:0] CmdCloseSet = 2'd2;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StScan = 4'b0100,
    StEmit = 4'b1000
  } state_e;

endpackage

[hdl/modular_sum_key_sorter.sv]
// Top level of the modular sum key sorter: sequencer, serial reducer and key memory.
// Depends on msks_pkg.
//
// Each add or close-list beat runs the running sum through one shared serial
// restoring reducer that retires one dividend bit per cycle, and the input
// stalls until all 32 dividend bits are retired.
// A close-set beat emits the stored lists in ascending key order, equal keys by
// ascending list index. Each result is found by one pass over the key memory
// (one read port, registered data) that picks the smallest (key, index) pair
// above the one emitted last; the output side can stall the emission. A close-set
// with no lists and an unused command do not leave the idle state. Lists closed
// beyond MAX_LISTS are dropped and flag overflow on every result of the set. The
// modulus register has its own write port; it is always ready and must be written
// only while the block is idle. A modulus of zero acts as one. The key memory
// needs no clearing pass.
module modular_sum_key_sorter #(
  parameter int unsigned MAX_LISTS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic [msks_pkg::KeyW-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [msks_pkg::IndexW-1:0] list_index_o,
  output logic [msks_pkg::KeyW-1:0]  list_key_o,
  output logic                       last_o,
  output logic                       overflow_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [msks_pkg::KeyW-1:0]  cfg_data_i
);
  import msks_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_LISTS);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LISTS);

  state_e state_q, state_d;

  logic [KeyW-1:0]  modulus_q;
  logic [KeyW-1:0]  sum_q;
  logic [CntW-1:0]  count_q;
  logic             ovf_q;

  // reducer
  logic [SumW-1:0]  dvd_q;
  logic [SumW-1:0]  rem_q;
  logic [StepW-1:0] step_q;
  logic             close_q;

  // scan
  logic [CntW-1:0]  scan_q;
  logic [CntW-1:0]  emitted_q;
  logic [KeyW-1:0]  rd_key_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic             rd_v_q;
  logic [KeyW-1:0]  best_key_q;
  logic [IdxW-1:0]  best_idx_q;
  logic             best_v_q;
  logic [KeyW-1:0]  prev_key_q;
  logic [IdxW-1:0]  prev_idx_q;

  logic [KeyW-1:0]  key_mem [MAX_LISTS];

  // output register
  logic             out_v_q;
  logic [IdxW-1:0]  out_idx_q;
  logic [KeyW-1:0]  out_key_q;
  logic             out_last_q;
  logic             out_ovf_q;

  logic             in_beat;
  logic             out_free;
  logic [KeyW-1:0]  mod_eff;
  logic [SumW-1:0]  rem_sh;
  logic             rem_ge;
  logic [SumW-1:0]  rem_next;
  logic             cand;
  logic             is_last;
  logic [IdxW+IndexW-1:0] idx_ext;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_free = !out_v_q || !out_stall_i;
  assign mod_eff  = (modulus_q == '0) ? KeyW'(1) : modulus_q;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh   = {rem_q[SumW-2:0], dvd_q[SumW-1]};
  assign rem_ge   = rem_sh >= {1'b0, mod_eff};
  assign rem_next = rem_ge ? (rem_sh - {1'b0, mod_eff}) : rem_sh;

  // Take the read entry if it sorts after the last emitted pair and before the best so far.
  assign cand = rd_v_q
             && ((emitted_q == '0) || ({rd_key_q, rd_idx_q} > {prev_key_q, prev_idx_q}))
             && (!best_v_q || ({rd_key_q, rd_idx_q} < {best_key_q, best_idx_q}));

  assign is_last = (emitted_q + CntW'(1)) == count_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_beat) begin
          if (cmd_i == CmdAdd || cmd_i == CmdCloseLst) begin
            state_d = StDiv;
          end else if (cmd_i == CmdCloseSet && count_q != '0) begin
            state_d = StScan;
          end
        end
      end
      StDiv: begin
        if (step_q == '0) state_d = StIdle;
      end
      StScan: begin
        if (scan_q == count_q && !rd_v_q) state_d = StEmit;
      end
      StEmit: begin
        if (out_free) state_d = is_last ? StIdle : StScan;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      modulus_q <= KeyW'(1);
      sum_q     <= '0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      step_q    <= '0;
      close_q   <= 1'b0;
      scan_q    <= '0;
      emitted_q <= '0;
      rd_v_q    <= 1'b0;
      best_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) modulus_q <= cfg_data_i;
      // Drop the taken beat unless the emit state refills the register.
      if (out_v_q && !out_stall_i && state_q != StEmit) out_v_q <= 1'b0;

      case (state_q)
        StIdle: begin
          if (in_beat) begin
            close_q   <= (cmd_i == CmdCloseLst);
            step_q    <= StepW'(SumW - 1);
            scan_q    <= '0;
            emitted_q <= '0;
            rd_v_q    <= 1'b0;
            best_v_q  <= 1'b0;
            if (cmd_i == CmdCloseSet && count_q == '0) begin
              sum_q <= '0;
              ovf_q <= 1'b0;
            end
          end
        end
        StDiv: begin
          step_q <= step_q - StepW'(1);
          if (step_q == '0) begin
            if (close_q) begin
              sum_q <= '0;
              if (count_q < MaxCnt) begin
                count_q <= count_q + CntW'(1);
              end else begin
                ovf_q <= 1'b1;
              end
            end else begin
              sum_q <= rem_next[KeyW-1:0];
            end
          end
        end
        StScan: begin
          rd_v_q <= scan_q < count_q;
          rd_idx_q <= scan_q[IdxW-1:0];
          if (scan_q < count_q) scan_q <= scan_q + CntW'(1);
          if (cand) begin
            best_v_q   <= 1'b1;
            best_key_q <= rd_key_q;
            best_idx_q <= rd_idx_q;
          end
        end
        StEmit: begin
          if (out_free) begin
            out_v_q    <= 1'b1;
            out_idx_q  <= best_idx_q;
            out_key_q  <= best_key_q;
            out_last_q <= is_last;
            out_ovf_q  <= ovf_q;
            prev_key_q <= best_key_q;
            prev_idx_q <= best_idx_q;
            emitted_q  <= emitted_q + CntW'(1);
            scan_q     <= '0;
            best_v_q   <= 1'b0;
            if (is_last) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              sum_q   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Reducer datapath; no reset needed.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_beat) begin
      rem_q <= '0;
      dvd_q <= (cmd_i == CmdAdd) ? ({1'b0, sum_q} + {1'b0, value_i}) : {1'b0, sum_q};
    end else if (state_q == StDiv) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[SumW-2:0], 1'b0};
    end
  end

  // Key memory: write the key on close-list, read one entry a cycle during the scan.
  always_ff @(posedge clk_i) begin
    if (state_q == StDiv && step_q == '0 && close_q && count_q < MaxCnt) begin
      key_mem[count_q[IdxW-1:0]] <= rem_next[KeyW-1:0];
    end
    rd_key_q <= key_mem[scan_q[IdxW-1:0]];
  end

  assign idx_ext = {{IndexW{1'b0}}, out_idx_q};

  assign in_stall_o   = state_q != StIdle;
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_v_q;
  assign list_index_o = idx_ext[IndexW-1:0];
  assign list_key_o   = out_key_q;
  assign last_o       = out_last_q;
  assign overflow_o   = out_ovf_q;

endmodule

[hdl/msks_checker.sv]
// Port-level checker for the modular sum key sorter, bound to the top level.
// Depends on msks_pkg.
module msks_port_props (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  cmd_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [msks_pkg::KeyW-1:0]   list_key_o,
  input logic                        cfg_ready_o
);
  import msks_pkg::*;

  // An add or close-list beat occupies the reducer on the next cycle.
  a_busy_after_list_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (cmd_i == CmdAdd || cmd_i == CmdCloseLst))
      |=> in_stall_o)
    else $error("input not stalled after add or close-list beat");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port not ready");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(list_key_o))
    else $error("output key changed while stalled");

endmodule

bind modular_sum_key_sorter msks_port_props u_msks_port_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .list_key_o  (list_key_o),
  .cfg_ready_o (cfg_ready_o)
);

[tb/sv/msks_checker.sv]
// Checker for the modular sum key sorter: watches the input, output and
// configuration channels, predicts sorted results and compares them.
// Depends on msks_pkg.
module msks_checker #(
  parameter int unsigned MAX_LISTS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [1:0]                  cmd_i,
  input  logic [msks_pkg::KeyW-1:0]   value_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [msks_pkg::IndexW-1:0] list_index_i,
  input  logic [msks_pkg::KeyW-1:0]   list_key_i,
  input  logic                        last_i,
  input  logic                        overflow_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [msks_pkg::KeyW-1:0]   cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          result_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import msks_pkg::*;

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [KeyW-1:0]   key;
    logic              last;
    logic              ovf;
  } sorted_entry_t;

  sorted_entry_t sorted_q[$];
  logic [KeyW-1:0]   list_keys[MAX_LISTS];
  logic [IndexW-1:0] list_ids[MAX_LISTS];
  logic [KeyW-1:0]   mod_reg;
  logic [KeyW-1:0]   open_sum;
  int unsigned       stored;
  logic              dropped;

  assign pending_o = sorted_q.size();

  function automatic logic [KeyW-1:0] reduce_mod(logic [KeyW:0] s);
    logic [KeyW:0] m;
    m = (mod_reg == '0) ? (KeyW+1)'(1) : {1'b0, mod_reg};
    return KeyW'(s % m);
  endfunction

  task automatic apply_beat(logic [1:0] cmd, logic [KeyW-1:0] val);
    logic [KeyW-1:0]   k;
    logic [IndexW-1:0] x;
    int j;
    sorted_entry_t e;
    if (cmd == CmdAdd) begin
      open_sum = reduce_mod({1'b0, open_sum} + {1'b0, val});
    end else if (cmd == CmdCloseLst) begin
      k = reduce_mod({1'b0, open_sum});
      open_sum = '0;
      if (stored < MAX_LISTS) begin
        list_keys[stored] = k;
        list_ids[stored] = IndexW'(stored);
        stored++;
      end else begin
        dropped = 1'b1;
      end
    end else if (cmd == CmdCloseSet) begin
      // stable insertion sort, ascending key
      for (int i = 1; i < stored; i++) begin
        k = list_keys[i];
        x = list_ids[i];
        j = i;
        while (j > 0 && list_keys[j-1] > k) begin
          list_keys[j] = list_keys[j-1];
          list_ids[j] = list_ids[j-1];
          j--;
        end
        list_keys[j] = k;
        list_ids[j] = x;
      end
      for (int i = 0; i < stored; i++) begin
        e.index = list_ids[i];
        e.key = list_keys[i];
        e.last = (i + 1 == stored);
        e.ovf = dropped;
        sorted_q.push_back(e);
      end
      open_sum = '0;
      stored = 0;
      dropped = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_entry_t exp_e;
    sorted_entry_t got_e;
    if (!rst_ni) begin
      mod_reg = KeyW'(1);
      open_sum = '0;
      stored = 0;
      dropped = 1'b0;
      sorted_q.delete();
      fail_count_o = 0;
      result_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got_e = '{list_index_i, list_key_i, last_i, overflow_i};
        result_count_o++;
        if (sorted_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result beat, actual %p", $time, got_e);
        end else begin
          exp_e = sorted_q.pop_front();
          if (got_e.index !== exp_e.index || got_e.key !== exp_e.key ||
              got_e.last !== exp_e.last || got_e.ovf !== exp_e.ovf) begin
            fail_count_o++;
            $display("%0t: result mismatch, expected %p, actual %p", $time, exp_e, got_e);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) mod_reg = cfg_data_i;
      if (in_valid_i && !in_stall_i) apply_beat(cmd_i, value_i);
    end
  end
endmodule

[tb/sv/tb.sv]
// Testbench top for the modular sum key sorter: clock, reset, stimulus and
// verdict. Depends on msks_pkg, modular_sum_key_sorter and msks_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msks_pkg::*;

  localparam int unsigned Lists = 64;
  localparam logic [1:0] CmdUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = CmdAdd;
  logic [KeyW-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IndexW-1:0] list_index;
  logic [KeyW-1:0] list_key;
  logic last, overflow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [KeyW-1:0] cfg_data = '0;
  int fail_count, pending, result_count;
  int beats_sent = 0;
  int sets_sent = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  modular_sum_key_sorter #(.MAX_LISTS(Lists)) u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .cmd_i(cmd), .value_i(value),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .list_index_o(list_index),
    .list_key_o(list_key), .last_o(last), .overflow_o(overflow),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  msks_checker #(.MAX_LISTS(Lists)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .cmd_i(cmd), .value_i(value),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .list_index_i(list_index),
    .list_key_i(list_key), .last_i(last), .overflow_i(overflow),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  // Mostly short gaps, now and then a long one, with no-gap stretches too.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KeyW-1:0] rand_value();
    case ($urandom_range(0, 4))
      0: return '1;
      1: return '0;
      2: return KeyW'($urandom_range(0, 20));
      default: return KeyW'($urandom());
    endcase
  endfunction

  // Randomly stall the result side.
  always @(negedge clk_i) begin
    if (!out_stall && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      fork
        begin
          repeat (gap_len() + 1) @(negedge clk_i);
          out_stall <= 1'b0;
        end
      join_none
    end
  end

  // Drive one beat at the falling edge; hold it until accepted at a rising edge.
  // Drop valid during a gap; with no gap the next beat follows directly.
  task automatic send_beat(logic [1:0] c, logic [KeyW-1:0] v);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd <= c;
    value <= v;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    beats_sent++;
    if (c == CmdCloseSet) sets_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_list(int unsigned n, bit small_vals);
    for (int i = 0; i < n; i++)
      send_beat(CmdAdd, small_vals ? KeyW'($urandom_range(0, 9)) : rand_value());
    send_beat(CmdCloseLst, KeyW'($urandom()));
  endtask

  // Drain expectations, then let the block settle before touching the modulus.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_modulus(logic [KeyW-1:0] m);
    wait_idle();
    cfg_data <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [KeyW-1:0] mods[6];
    mods = '{KeyW'(7), '1, KeyW'(0), KeyW'(1), KeyW'(3), KeyW'(1000)};
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty set, empty list, extremes, unused command, open list discarded.
    send_beat(CmdCloseSet, '0);
    send_beat(CmdCloseLst, '1);
    send_beat(CmdAdd, '1);
    send_beat(CmdCloseLst, '0);
    send_beat(CmdCloseSet, '0);
    write_modulus('1);
    send_beat(CmdAdd, '1);
    send_beat(CmdAdd, '1);
    send_beat(CmdCloseLst, '0);
    send_beat(CmdAdd, KeyW'(5));
    send_beat(CmdCloseLst, '0);
    send_beat(CmdUnused, '1);
    send_beat(CmdAdd, KeyW'(5));
    send_beat(CmdCloseLst, '0);
    send_beat(CmdAdd, KeyW'(9));
    send_beat(CmdCloseSet, '1);
    write_modulus('0);
    send_beat(CmdAdd, KeyW'(12345));
    send_beat(CmdCloseLst, '0);
    send_beat(CmdCloseSet, '0);

    // Overflow: fill past capacity with empty lists, then close the set.
    write_modulus(KeyW'(3));
    for (int i = 0; i < Lists + 2; i++) send_beat(CmdCloseLst, '0);
    send_beat(CmdCloseSet, '0);

    // Random sets under several moduli; small sets, small values for ties.
    foreach (mods[p]) begin
      write_modulus(mods[p]);
      for (int s = 0; s < 4; s++) begin
        int unsigned lists;
        bit small_vals;
        lists = $urandom_range(1, 5);
        small_vals = $urandom_range(0, 1);
        for (int l = 0; l < lists; l++) send_list($urandom_range(0, 3), small_vals);
        if ($urandom_range(0, 9) == 0) send_beat(CmdUnused, rand_value());
        if ($urandom_range(0, 4) == 0) send_beat(CmdAdd, rand_value());
        send_beat(CmdCloseSet, rand_value());
      end
    end

    wait_idle();
    $display("Sent %0d input beats in %0d sets; checked %0d sorted result beats.",
             beats_sent, sets_sent, result_count);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("Run timed out with %0d results still expected.", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[filelist.f]
hdl/msks_pkg.sv
hdl/modular_sum_key_sorter.sv
hdl/msks_checker.sv
tb/sv/msks_checker.sv
tb/sv/tb.sv
